/* rtl/core/ulsc_pkg.sv */
// Package for the UART link sleep controller.
// Holds the event codes, beat types and defaults; depends on nothing.
package ulsc_pkg;

	localparam int unsigned COUNT_WIDTH_DEF = 16;
	localparam int unsigned CFG_WIDTH       = 16;
	localparam int unsigned PADDR_WIDTH     = 3;
	localparam int unsigned PDATA_WIDTH     = 32;

	localparam logic [CFG_WIDTH-1:0] IDLE_TICKS_RST = 16'd1000;

	localparam logic [PADDR_WIDTH-1:0] ADDR_IDLE_TICKS = 3'd0;

	typedef enum logic [2:0] {
		OP_WAKE       = 3'd0,
		OP_TXDATA     = 3'd1,
		OP_TICK       = 3'd2,
		OP_LINK_REG   = 3'd3,
		OP_LINK_UNREG = 3'd4,
		OP_START      = 3'd5,
		OP_STOP       = 3'd6,
		OP_FORCE_PIN  = 3'd7
	} opcode_t;

	typedef struct packed {
		opcode_t opcode;
		logic    wake_line;
		logic    tx_empty;
		logic    pin_value;
	} in_beat_t;

	typedef struct packed {
		logic host_wake_out;
		logic uart_enabled;
		logic sleeping;
		logic protocol_active;
		logic tx_pending;
		logic link_running;
		logic timer_armed;
	} out_beat_t;

endpackage

/* rtl/core/uart_link_sleep_controller.sv */
// Top level of the UART link sleep controller: event decode, flags, idle countdown.
// Depends on ulsc_pkg.
//
// Channel  | Direction | Handshake          | Beat
// in       | input     | in_valid/in_ready  | ulsc_pkg::in_beat_t
// out      | output    | out_valid/out_ready| ulsc_pkg::out_beat_t
// cfg      | input     | APB psel/penable   | idle_timeout_ticks at 0x0
//
// Each event's state update and result are formed in one pass, and the result
// lands in the output register at the accepting edge.
// A new event is taken every cycle while the output register is empty or being drained.
// Reset clears the flags but sets the UART-enabled flag, loads the default timeout and empties the output register.
// A stalled output blocks the input only while its beat is not taken.
module uart_link_sleep_controller #(
	parameter int unsigned COUNT_WIDTH = ulsc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  ulsc_pkg::in_beat_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output ulsc_pkg::out_beat_t               out_data,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ulsc_pkg::PADDR_WIDTH-1:0]  paddr,
	input  logic [ulsc_pkg::PDATA_WIDTH-1:0]  pwdata,
	output logic [ulsc_pkg::PDATA_WIDTH-1:0]  prdata,
	output logic                              pready
);

	localparam logic [31:0] CntMax = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

	logic [ulsc_pkg::CFG_WIDTH-1:0] idle_ticks_q;
	logic asleep_q, proto_q, txdata_q, wake_pin_q, uart_on_q, link_q, running_q, run_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic out_valid_q;
	ulsc_pkg::out_beat_t out_data_q;

	logic asleep_n, proto_n, txdata_n, wake_pin_n, uart_on_n, link_n, running_n, run_n;
	logic [COUNT_WIDTH-1:0] count_n;
	logic [COUNT_WIDTH-1:0] arm_val;
	logic [COUNT_WIDTH-1:0] count_dec;
	logic [31:0] cfg_ext;
	logic in_fire;

	assign pready   = 1'b1;
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign prdata = (paddr == ulsc_pkg::ADDR_IDLE_TICKS) ?
		ulsc_pkg::PDATA_WIDTH'(idle_ticks_q) : '0;

	always_comb begin
		cfg_ext = 32'(idle_ticks_q);
		if (cfg_ext == 32'd0) begin
			cfg_ext = 32'd1;
		end
		if (cfg_ext > CntMax) begin
			cfg_ext = CntMax;
		end
		arm_val = cfg_ext[COUNT_WIDTH-1:0];
	end

	assign count_dec = count_q - COUNT_WIDTH'(1);

	always_comb begin
		asleep_n   = asleep_q;
		proto_n    = proto_q;
		txdata_n   = txdata_q;
		wake_pin_n = wake_pin_q;
		uart_on_n  = uart_on_q;
		link_n     = link_q;
		running_n  = running_q;
		run_n      = run_q;
		count_n    = count_q;
		case (in_data.opcode)
			ulsc_pkg::OP_WAKE: begin
				if (proto_q && link_q) begin
					running_n = 1'b1;
					if (in_data.wake_line) begin
						if (wake_pin_q) begin
							if (!asleep_q) begin
								if (in_data.tx_empty) begin
									asleep_n  = 1'b1;
									running_n = 1'b0;
									uart_on_n = 1'b0;
								end else begin
									count_n = arm_val;
									run_n   = 1'b1;
								end
							end
						end else begin
							count_n = arm_val;
							run_n   = 1'b1;
						end
					end else if (asleep_q) begin
						asleep_n  = 1'b0;
						uart_on_n = 1'b1;
						count_n   = arm_val;
						run_n     = 1'b1;
					end
				end
			end
			ulsc_pkg::OP_TXDATA: begin
				running_n = 1'b1;
				txdata_n  = 1'b1;
				if (wake_pin_q) begin
					wake_pin_n = 1'b0;
					if (asleep_q) begin
						asleep_n  = 1'b0;
						uart_on_n = 1'b1;
					end
				end
			end
			ulsc_pkg::OP_TICK: begin
				if (run_q) begin
					count_n = count_dec;
					if (count_dec == '0) begin
						run_n = 1'b0;
						if (!wake_pin_q) begin
							wake_pin_n = 1'b1;
							txdata_n   = 1'b0;
						end
						if (in_data.wake_line) begin
							if (!asleep_q) begin
								if (!link_q || in_data.tx_empty) begin
									asleep_n  = 1'b1;
									running_n = 1'b0;
									uart_on_n = 1'b0;
								end else begin
									count_n = arm_val;
									run_n   = 1'b1;
								end
							end
						end else begin
							count_n = arm_val;
							run_n   = 1'b1;
						end
					end
				end
			end
			ulsc_pkg::OP_LINK_REG: begin
				link_n = 1'b1;
			end
			ulsc_pkg::OP_LINK_UNREG: begin
				link_n = 1'b0;
			end
			ulsc_pkg::OP_START: begin
				if (!proto_q) begin
					count_n    = arm_val;
					run_n      = 1'b1;
					wake_pin_n = 1'b0;
					proto_n    = 1'b1;
				end
			end
			ulsc_pkg::OP_STOP: begin
				if (proto_q) begin
					wake_pin_n = 1'b0;
					run_n      = 1'b0;
					proto_n    = 1'b0;
					if (asleep_q) begin
						asleep_n  = 1'b0;
						uart_on_n = 1'b1;
					end
				end
			end
			default: begin
				wake_pin_n = in_data.pin_value;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_ticks_q <= ulsc_pkg::IDLE_TICKS_RST;
		end else if (psel && penable && pwrite && paddr == ulsc_pkg::ADDR_IDLE_TICKS) begin
			idle_ticks_q <= pwdata[ulsc_pkg::CFG_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asleep_q    <= 1'b0;
			proto_q     <= 1'b0;
			txdata_q    <= 1'b0;
			wake_pin_q  <= 1'b0;
			uart_on_q   <= 1'b1;
			link_q      <= 1'b0;
			running_q   <= 1'b0;
			run_q       <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				asleep_q   <= asleep_n;
				proto_q    <= proto_n;
				txdata_q   <= txdata_n;
				wake_pin_q <= wake_pin_n;
				uart_on_q  <= uart_on_n;
				link_q     <= link_n;
				running_q  <= running_n;
				run_q      <= run_n;
				count_q    <= count_n;
			end
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q.host_wake_out   <= wake_pin_n;
			out_data_q.uart_enabled    <= uart_on_n;
			out_data_q.sleeping        <= asleep_n;
			out_data_q.protocol_active <= proto_n;
			out_data_q.tx_pending      <= txdata_n;
			out_data_q.link_running    <= running_n;
			out_data_q.timer_armed     <= run_n;
		end
	end

endmodule

/* rtl/core/ulsc_checker.sv */
// Port-level checks for the UART link sleep controller and their bind.
// Depends on ulsc_pkg and uart_link_sleep_controller.
module ulsc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input ulsc_pkg::in_beat_t                in_data,
	input logic                              out_valid,
	input logic                              out_ready,
	input ulsc_pkg::out_beat_t               out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Result beat changed while stalled.");

	a_power_sleep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.uart_enabled != out_data.sleeping)
		else $error("UART power disagrees with the sleep flag.");

	a_timer_proto: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.timer_armed |-> out_data.protocol_active)
		else $error("Idle countdown armed with the protocol stopped.");

	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.opcode == ulsc_pkg::OP_STOP |=>
		out_valid && !out_data.protocol_active && !out_data.timer_armed)
		else $error("Stop event left the protocol or countdown running.");

	a_force_pin: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.opcode == ulsc_pkg::OP_FORCE_PIN |=>
		out_valid && out_data.host_wake_out == $past(in_data.pin_value))
		else $error("Forced host-wake level not reflected.");

endmodule

bind uart_link_sleep_controller ulsc_checker u_ulsc_checker (.*);
